// File: rtl/aes_pkg.sv
// Shared AES-128 types, constants and byte-level functions.
`default_nettype none
package aes_pkg;

    localparam int NumRounds = 10;
    localparam logic [3:0] CipherIndex = 4'd10;

    typedef logic [127:0] block_t;

    typedef struct packed {
        logic       valid;
        block_t     key;
        block_t     state;
    } stage_t;

    function automatic logic [7:0] sbox(input logic [7:0] a);
        logic [7:0] v;
        begin
            case (a)
                8'h00: v = 8'h63; 8'h01: v = 8'h7c; 8'h02: v = 8'h77; 8'h03: v = 8'h7b;
                8'h04: v = 8'hf2; 8'h05: v = 8'h6b; 8'h06: v = 8'h6f; 8'h07: v = 8'hc5;
                8'h08: v = 8'h30; 8'h09: v = 8'h01; 8'h0a: v = 8'h67; 8'h0b: v = 8'h2b;
                8'h0c: v = 8'hfe; 8'h0d: v = 8'hd7; 8'h0e: v = 8'hab; 8'h0f: v = 8'h76;
                8'h10: v = 8'hca; 8'h11: v = 8'h82; 8'h12: v = 8'hc9; 8'h13: v = 8'h7d;
                8'h14: v = 8'hfa; 8'h15: v = 8'h59; 8'h16: v = 8'h47; 8'h17: v = 8'hf0;
                8'h18: v = 8'had; 8'h19: v = 8'hd4; 8'h1a: v = 8'ha2; 8'h1b: v = 8'haf;
                8'h1c: v = 8'h9c; 8'h1d: v = 8'ha4; 8'h1e: v = 8'h72; 8'h1f: v = 8'hc0;
                8'h20: v = 8'hb7; 8'h21: v = 8'hfd; 8'h22: v = 8'h93; 8'h23: v = 8'h26;
                8'h24: v = 8'h36; 8'h25: v = 8'h3f; 8'h26: v = 8'hf7; 8'h27: v = 8'hcc;
                8'h28: v = 8'h34; 8'h29: v = 8'ha5; 8'h2a: v = 8'he5; 8'h2b: v = 8'hf1;
                8'h2c: v = 8'h71; 8'h2d: v = 8'hd8; 8'h2e: v = 8'h31; 8'h2f: v = 8'h15;
                8'h30: v = 8'h04; 8'h31: v = 8'hc7; 8'h32: v = 8'h23; 8'h33: v = 8'hc3;
                8'h34: v = 8'h18; 8'h35: v = 8'h96; 8'h36: v = 8'h05; 8'h37: v = 8'h9a;
                8'h38: v = 8'h07; 8'h39: v = 8'h12; 8'h3a: v = 8'h80; 8'h3b: v = 8'he2;
                8'h3c: v = 8'heb; 8'h3d: v = 8'h27; 8'h3e: v = 8'hb2; 8'h3f: v = 8'h75;
                8'h40: v = 8'h09; 8'h41: v = 8'h83; 8'h42: v = 8'h2c; 8'h43: v = 8'h1a;
                8'h44: v = 8'h1b; 8'h45: v = 8'h6e; 8'h46: v = 8'h5a; 8'h47: v = 8'ha0;
                8'h48: v = 8'h52; 8'h49: v = 8'h3b; 8'h4a: v = 8'hd6; 8'h4b: v = 8'hb3;
                8'h4c: v = 8'h29; 8'h4d: v = 8'he3; 8'h4e: v = 8'h2f; 8'h4f: v = 8'h84;
                8'h50: v = 8'h53; 8'h51: v = 8'hd1; 8'h52: v = 8'h00; 8'h53: v = 8'hed;
                8'h54: v = 8'h20; 8'h55: v = 8'hfc; 8'h56: v = 8'hb1; 8'h57: v = 8'h5b;
                8'h58: v = 8'h6a; 8'h59: v = 8'hcb; 8'h5a: v = 8'hbe; 8'h5b: v = 8'h39;
                8'h5c: v = 8'h4a; 8'h5d: v = 8'h4c; 8'h5e: v = 8'h58; 8'h5f: v = 8'hcf;
                8'h60: v = 8'hd0; 8'h61: v = 8'hef; 8'h62: v = 8'haa; 8'h63: v = 8'hfb;
                8'h64: v = 8'h43; 8'h65: v = 8'h4d; 8'h66: v = 8'h33; 8'h67: v = 8'h85;
                8'h68: v = 8'h45; 8'h69: v = 8'hf9; 8'h6a: v = 8'h02; 8'h6b: v = 8'h7f;
                8'h6c: v = 8'h50; 8'h6d: v = 8'h3c; 8'h6e: v = 8'h9f; 8'h6f: v = 8'ha8;
                8'h70: v = 8'h51; 8'h71: v = 8'ha3; 8'h72: v = 8'h40; 8'h73: v = 8'h8f;
                8'h74: v = 8'h92; 8'h75: v = 8'h9d; 8'h76: v = 8'h38; 8'h77: v = 8'hf5;
                8'h78: v = 8'hbc; 8'h79: v = 8'hb6; 8'h7a: v = 8'hda; 8'h7b: v = 8'h21;
                8'h7c: v = 8'h10; 8'h7d: v = 8'hff; 8'h7e: v = 8'hf3; 8'h7f: v = 8'hd2;
                8'h80: v = 8'hcd; 8'h81: v = 8'h0c; 8'h82: v = 8'h13; 8'h83: v = 8'hec;
                8'h84: v = 8'h5f; 8'h85: v = 8'h97; 8'h86: v = 8'h44; 8'h87: v = 8'h17;
                8'h88: v = 8'hc4; 8'h89: v = 8'ha7; 8'h8a: v = 8'h7e; 8'h8b: v = 8'h3d;
                8'h8c: v = 8'h64; 8'h8d: v = 8'h5d; 8'h8e: v = 8'h19; 8'h8f: v = 8'h73;
                8'h90: v = 8'h60; 8'h91: v = 8'h81; 8'h92: v = 8'h4f; 8'h93: v = 8'hdc;
                8'h94: v = 8'h22; 8'h95: v = 8'h2a; 8'h96: v = 8'h90; 8'h97: v = 8'h88;
                8'h98: v = 8'h46; 8'h99: v = 8'hee; 8'h9a: v = 8'hb8; 8'h9b: v = 8'h14;
                8'h9c: v = 8'hde; 8'h9d: v = 8'h5e; 8'h9e: v = 8'h0b; 8'h9f: v = 8'hdb;
                8'ha0: v = 8'he0; 8'ha1: v = 8'h32; 8'ha2: v = 8'h3a; 8'ha3: v = 8'h0a;
                8'ha4: v = 8'h49; 8'ha5: v = 8'h06; 8'ha6: v = 8'h24; 8'ha7: v = 8'h5c;
                8'ha8: v = 8'hc2; 8'ha9: v = 8'hd3; 8'haa: v = 8'hac; 8'hab: v = 8'h62;
                8'hac: v = 8'h91; 8'had: v = 8'h95; 8'hae: v = 8'he4; 8'haf: v = 8'h79;
                8'hb0: v = 8'he7; 8'hb1: v = 8'hc8; 8'hb2: v = 8'h37; 8'hb3: v = 8'h6d;
                8'hb4: v = 8'h8d; 8'hb5: v = 8'hd5; 8'hb6: v = 8'h4e; 8'hb7: v = 8'ha9;
                8'hb8: v = 8'h6c; 8'hb9: v = 8'h56; 8'hba: v = 8'hf4; 8'hbb: v = 8'hea;
                8'hbc: v = 8'h65; 8'hbd: v = 8'h7a; 8'hbe: v = 8'hae; 8'hbf: v = 8'h08;
                8'hc0: v = 8'hba; 8'hc1: v = 8'h78; 8'hc2: v = 8'h25; 8'hc3: v = 8'h2e;
                8'hc4: v = 8'h1c; 8'hc5: v = 8'ha6; 8'hc6: v = 8'hb4; 8'hc7: v = 8'hc6;
                8'hc8: v = 8'he8; 8'hc9: v = 8'hdd; 8'hca: v = 8'h74; 8'hcb: v = 8'h1f;
                8'hcc: v = 8'h4b; 8'hcd: v = 8'hbd; 8'hce: v = 8'h8b; 8'hcf: v = 8'h8a;
                8'hd0: v = 8'h70; 8'hd1: v = 8'h3e; 8'hd2: v = 8'hb5; 8'hd3: v = 8'h66;
                8'hd4: v = 8'h48; 8'hd5: v = 8'h03; 8'hd6: v = 8'hf6; 8'hd7: v = 8'h0e;
                8'hd8: v = 8'h61; 8'hd9: v = 8'h35; 8'hda: v = 8'h57; 8'hdb: v = 8'hb9;
                8'hdc: v = 8'h86; 8'hdd: v = 8'hc1; 8'hde: v = 8'h1d; 8'hdf: v = 8'h9e;
                8'he0: v = 8'he1; 8'he1: v = 8'hf8; 8'he2: v = 8'h98; 8'he3: v = 8'h11;
                8'he4: v = 8'h69; 8'he5: v = 8'hd9; 8'he6: v = 8'h8e; 8'he7: v = 8'h94;
                8'he8: v = 8'h9b; 8'he9: v = 8'h1e; 8'hea: v = 8'h87; 8'heb: v = 8'he9;
                8'hec: v = 8'hce; 8'hed: v = 8'h55; 8'hee: v = 8'h28; 8'hef: v = 8'hdf;
                8'hf0: v = 8'h8c; 8'hf1: v = 8'ha1; 8'hf2: v = 8'h89; 8'hf3: v = 8'h0d;
                8'hf4: v = 8'hbf; 8'hf5: v = 8'he6; 8'hf6: v = 8'h42; 8'hf7: v = 8'h68;
                8'hf8: v = 8'h41; 8'hf9: v = 8'h99; 8'hfa: v = 8'h2d; 8'hfb: v = 8'h0f;
                8'hfc: v = 8'hb0; 8'hfd: v = 8'h54; 8'hfe: v = 8'hbb; 8'hff: v = 8'h16;
                default: v = 8'h00;
            endcase
            return v;
        end
    endfunction

    function automatic logic [7:0] rcon(input logic [3:0] r);
        logic [7:0] v;
        begin
            case (r)
                4'd0: v = 8'h01; 4'd1: v = 8'h02; 4'd2: v = 8'h04; 4'd3: v = 8'h08;
                4'd4: v = 8'h10; 4'd5: v = 8'h20; 4'd6: v = 8'h40; 4'd7: v = 8'h80;
                4'd8: v = 8'h1b; 4'd9: v = 8'h36;
                default: v = 8'h00;
            endcase
            return v;
        end
    endfunction

    // byte i of a block; byte 0 is the top byte
    function automatic logic [7:0] byte_at(input block_t b, input int i);
        return b[127 - 8*i -: 8];
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] v);
        return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
    endfunction

endpackage
`default_nettype wire

// File: rtl/aes_key_step.sv
// One step of the AES-128 key schedule.
`default_nettype none
module aes_key_step
    import aes_pkg::*;
(
    input  wire logic [3:0] round,
    input  wire block_t     prev_key,
    output block_t          next_key
);
    logic [31:0] t;
    logic [31:0] w0, w1, w2, w3;

    always_comb
    begin
        t = {sbox(byte_at(prev_key, 13)) ^ rcon(round), sbox(byte_at(prev_key, 14)),
             sbox(byte_at(prev_key, 15)), sbox(byte_at(prev_key, 12))};
        w0 = prev_key[127:96] ^ t;
        w1 = prev_key[95:64] ^ w0;
        w2 = prev_key[63:32] ^ w1;
        w3 = prev_key[31:0] ^ w2;
        next_key = {w0, w1, w2, w3};
    end
endmodule
`default_nettype wire

// File: rtl/aes_round.sv
// One AES round: SubBytes, ShiftRows, optional MixColumns, AddRoundKey.
`default_nettype none
module aes_round
    import aes_pkg::*;
(
    input  wire logic mix,
    input  wire block_t state_in,
    input  wire block_t round_key,
    output block_t      state_out
);
    logic [7:0] t [16];
    logic [7:0] m [16];
    logic [7:0] a0, a1, a2, a3, all;

    always_comb
    begin
        a0 = '0; a1 = '0; a2 = '0; a3 = '0; all = '0;
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
                t[4*c + r] = sbox(byte_at(state_in, 4*((c + r) & 3) + r));
        for (int c = 0; c < 4; c++)
        begin
            a0 = t[4*c]; a1 = t[4*c + 1]; a2 = t[4*c + 2]; a3 = t[4*c + 3];
            all = a0 ^ a1 ^ a2 ^ a3;
            m[4*c]     = mix ? (a0 ^ all ^ xtime(a0 ^ a1)) : a0;
            m[4*c + 1] = mix ? (a1 ^ all ^ xtime(a1 ^ a2)) : a1;
            m[4*c + 2] = mix ? (a2 ^ all ^ xtime(a2 ^ a3)) : a2;
            m[4*c + 3] = mix ? (a3 ^ all ^ xtime(a3 ^ a0)) : a3;
        end
        for (int i = 0; i < 16; i++)
            state_out[127 - 8*i -: 8] = m[i] ^ byte_at(round_key, i);
    end
endmodule
`default_nettype wire

// File: rtl/aes128_encrypt_with_round_keys.sv
// Top level: pipelined AES-128 encryption with round key reporting.
// Usage:
//   An item (plaintext and key, each as hi/lo halves) transfers at a rising
//   edge with start high and busy low. Busy is high while the result port
//   is still reporting earlier items and the pipeline cannot advance.
//   Stage 0 registers the initial AddRoundKey; stages 1..10 each hold the
//   result of one key-schedule step and one cipher round.
//   When an item moves into the last stage, its ten round keys are copied
//   into a key buffer and the last stage holds the ciphertext.
//   Results: eleven per item on strobe, one per cycle, round keys 1..10
//   (result_index 0..9) then the ciphertext (index 10, last_result high).
//   The first result appears when the item lands in the last stage; the
//   ciphertext follows after the ten round keys.
//   The single result port sets how often items can complete; the rounds
//   advance one stage per cycle while busy is low, and items overlap.
//   The receiver cannot stall; results are never held.
//   Reset clears all valid bits and the output sequencer.
`default_nettype none
module aes128_encrypt_with_round_keys
    import aes_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [63:0] plaintext_hi,
    input  wire logic [63:0] plaintext_lo,
    input  wire logic [63:0] cipher_key_hi,
    input  wire logic [63:0] cipher_key_lo,
    output logic             strobe,
    output logic [3:0]       result_index,
    output logic [63:0]      block_hi,
    output logic [63:0]      block_lo,
    output logic             last_result
);
    // stage 0 holds input after initial AddRoundKey; stage r holds round r
    stage_t     pipe_reg [NumRounds + 1];
    stage_t     pipe_next [NumRounds + 1];
    block_t     key_out [NumRounds];
    block_t     st_out [NumRounds];
    // gathered round keys of one item; the ciphertext stays in the last stage
    block_t     keys_reg [NumRounds], keys_next [NumRounds];
    logic [3:0] out_cnt_reg, out_cnt_next;
    logic       out_act_reg, out_act_next;
    logic       accept, advance, land;

    // pipeline advances unless an item would reach the end while the output
    // sequencer has not yet reached the ciphertext of the previous one
    assign land = pipe_reg[NumRounds - 1].valid;
    assign advance = !(land && out_act_reg && out_cnt_reg != CipherIndex);
    assign busy = !advance;
    assign accept = start && advance;

    for (genvar g = 0; g < NumRounds; g++)
    begin : g_rnd
        aes_key_step u_key (
            .round    (4'(g)),
            .prev_key (pipe_reg[g].key),
            .next_key (key_out[g])
        );
        aes_round u_rnd (
            .mix       (g != NumRounds - 1),
            .state_in  (pipe_reg[g].state),
            .round_key (key_out[g]),
            .state_out (st_out[g])
        );
    end

    always_comb
    begin
        pipe_next = pipe_reg;
        if (advance)
        begin
            pipe_next[0].valid = accept;
            pipe_next[0].key   = {cipher_key_hi, cipher_key_lo};
            pipe_next[0].state = {plaintext_hi, plaintext_lo} ^ {cipher_key_hi, cipher_key_lo};
            for (int i = 0; i < NumRounds; i++)
            begin
                // last stage keeps the ciphertext until the next item lands
                if (i != NumRounds - 1 || pipe_reg[i].valid)
                begin
                    pipe_next[i + 1].valid = pipe_reg[i].valid;
                    pipe_next[i + 1].key   = key_out[i];
                    pipe_next[i + 1].state = st_out[i];
                end
            end
        end
    end

    // Keep a copy of every round key as the item moves: row s belongs to the
    // item in stage s + 1 and holds round keys 1..s + 1. On landing, the row
    // of stage 9 plus the fresh tenth key go to keys_reg.
    logic [127:0] hist_reg [NumRounds - 1][NumRounds - 1];
    logic [127:0] hist_next [NumRounds - 1][NumRounds - 1];

    always_comb
    begin
        hist_next = hist_reg;
        if (advance)
        begin
            for (int s = NumRounds - 2; s > 0; s--)
            begin
                hist_next[s] = hist_reg[s - 1];
                hist_next[s][s] = key_out[s];
            end
            hist_next[0][0] = key_out[0];
        end
    end

    always_comb
    begin
        keys_next = keys_reg;
        out_cnt_next = out_cnt_reg;
        out_act_next = out_act_reg;
        if (out_act_reg)
        begin
            if (out_cnt_reg == CipherIndex)
                out_act_next = 1'b0;
            else
                out_cnt_next = out_cnt_reg + 4'd1;
        end
        if (advance && pipe_reg[NumRounds - 1].valid)
        begin
            for (int k = 0; k < NumRounds - 1; k++)
                keys_next[k] = hist_reg[NumRounds - 2][k];
            keys_next[NumRounds - 1] = key_out[NumRounds - 1];
            out_cnt_next = '0;
            out_act_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= NumRounds; i++)
                pipe_reg[i] <= '0;
            out_cnt_reg <= '0;
            out_act_reg <= 1'b0;
        end
        else
        begin
            pipe_reg <= pipe_next;
            out_cnt_reg <= out_cnt_next;
            out_act_reg <= out_act_next;
        end
    end

    always_ff @(posedge clk)
    begin
        keys_reg <= keys_next;
        hist_reg <= hist_next;
    end

    logic [127:0] res;
    always_comb
    begin
        res = pipe_reg[NumRounds].state;
        if (out_cnt_reg != CipherIndex)
            res = keys_reg[out_cnt_reg];
    end

    assign strobe       = out_act_reg;
    assign result_index = out_cnt_reg;
    assign block_hi     = res[127:64];
    assign block_lo     = res[63:0];
    assign last_result  = out_act_reg && out_cnt_reg == CipherIndex;

    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> result_index <= CipherIndex)
        else $error("result index out of range");
    a_seq: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !last_result |=> strobe && result_index == $past(result_index) + 4'd1)
        else $error("result sequence broken");
    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> strobe && !last_result)
        else $error("pipeline stalled without output pressure");
endmodule
`default_nettype wire
